/* sv/cdss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdss_pkg: shared types for the coordinate deque
// Command codes, per-cell operation codes, control struct and FSM states.
// ----------------------------------------------------------------------------
package cdss_pkg;

  // Command codes carried on in_command
  localparam logic [2:0] CMD_INS_HEAD   = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL   = 3'd1;
  localparam logic [2:0] CMD_SHIFT_HEAD = 3'd2;
  localparam logic [2:0] CMD_SHIFT_TAIL = 3'd3;
  localparam logic [2:0] CMD_QUERY      = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  // Hit flags are ORed in groups of this many cells
  localparam int unsigned HIT_GROUP = 32;

  // What every cell does at each clock
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_APPEND,
    CELL_TAKE_RIGHT,
    CELL_MATCH
  } cell_op_t;

  // Broadcast control from the sequencer to the chain
  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  // Request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_RESOLVE
  } seq_state_t;

endpackage

/* sv/cdss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdss_cell: one slot of the coordinate chain
// Holds one pair, moves it to either neighbour, loads a new pair and
// registers its own match flag for a lookup.
// ----------------------------------------------------------------------------
module cdss_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                    clk,
  input  cdss_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]        count,
  input  logic [CNT_W-1:0]        count_m1,
  input  logic [COORD_BITS-1:0]   new_x,
  input  logic [COORD_BITS-1:0]   new_y,
  input  logic [COORD_BITS-1:0]   left_x,
  input  logic [COORD_BITS-1:0]   left_y,
  input  logic [COORD_BITS-1:0]   right_x,
  input  logic [COORD_BITS-1:0]   right_y,
  output logic [COORD_BITS-1:0]   x,
  output logic [COORD_BITS-1:0]   y,
  output logic                    match
);
  import cdss_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic                  match_r, match_nxt;
  logic                  in_use;

  // slot holds a live entry
  assign in_use = MY_IDX < count;

  // next slot contents
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    match_nxt = match_r;
    case (ctrl.op)
      CELL_TAKE_LEFT: begin
        x_nxt = left_x;
        y_nxt = left_y;
      end
      CELL_APPEND: begin
        if (MY_IDX == count) begin
          x_nxt = new_x;
          y_nxt = new_y;
        end
      end
      CELL_TAKE_RIGHT: begin
        if (MY_IDX == count_m1) begin
          x_nxt = new_x;
          y_nxt = new_y;
        end else begin
          x_nxt = right_x;
          y_nxt = right_y;
        end
      end
      CELL_MATCH: begin
        match_nxt = in_use && (x_r == new_x) && (y_r == new_y);
      end
      default: begin
      end
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    match_r <= match_nxt;
  end

  assign x     = x_r;
  assign y     = y_r;
  assign match = match_r;

endmodule

/* sv/cdss_hit_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdss_hit_tree: registered OR of the cell match flags
// First level ORs groups of cells into registers, the second level ORs
// the group registers.
// ----------------------------------------------------------------------------
module cdss_hit_tree #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] match,
  output logic             hit
);
  import cdss_pkg::*;

  localparam int unsigned GROUPS = (DEPTH + HIT_GROUP - 1) / HIT_GROUP;

  logic [GROUPS-1:0] grp_r, grp_nxt;

  // group ORs, last group may be short
  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      for (int j = 0; j < HIT_GROUP; j++) begin
        if (g * HIT_GROUP + j < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | match[g * HIT_GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign hit = |grp_r;

endmodule

/* sv/coordinate_deque_shift_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_deque_shift_search: bounded deque of coordinate pairs
// Chain of cells holding up to DEPTH pairs, head at cell 0, with insert
// and shift-in at either end, lookup and clear.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_ready  | command, coord_x, coord_y
//  out_    | output    | out_valid/out_ready| found, length, overflow
//
//  Insert, shift and clear requests load their result into the output
//  register at acceptance.
//  A lookup request passes in order through cell compare, group OR
//  register and final OR into the output register.
//  One request is in flight at a time; a new one is taken when the output
//  register is empty or being read in that cycle.
//  Reset empties the deque; cell contents are not cleared.
// ----------------------------------------------------------------------------
module coordinate_deque_shift_search #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic [COORD_BITS-1:0]         in_coord_x,
  input  logic [COORD_BITS-1:0]         in_coord_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [$clog2(DEPTH+1)-1:0]    out_length,
  output logic                          out_overflow
);
  import cdss_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  seq_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      count_m1;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [CNT_W-1:0]      out_length_r, out_length_nxt;
  logic                  out_overflow_r, out_overflow_nxt;
  logic                  accept;
  logic                  is_query;
  logic                  full, empty;
  logic                  hit;
  cell_ctrl_t            ctrl;

  logic [COORD_BITS-1:0] x_w [DEPTH];
  logic [COORD_BITS-1:0] y_w [DEPTH];
  logic [DEPTH-1:0]      match_w;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_query = (in_command == CMD_QUERY);
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign count_m1 = count_r - CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) state_nxt = ST_GATHER;
      end
      ST_GATHER:  state_nxt = ST_RESOLVE;
      ST_RESOLVE: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // request decode, cell control and result register
  always_comb begin
    ctrl.op          = CELL_HOLD;
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_length_nxt   = out_length_r;
    out_overflow_nxt = out_overflow_r;
    if (accept) begin
      case (in_command)
        CMD_INS_HEAD: begin
          if (!full) begin
            ctrl.op   = CELL_TAKE_LEFT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_INS_TAIL: begin
          if (!full) begin
            ctrl.op   = CELL_APPEND;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_SHIFT_HEAD: begin
          if (!empty) ctrl.op = CELL_TAKE_LEFT;
        end
        CMD_SHIFT_TAIL: begin
          if (!empty) ctrl.op = CELL_TAKE_RIGHT;
        end
        CMD_QUERY: ctrl.op   = CELL_MATCH;
        CMD_CLEAR: count_nxt = '0;
        default: begin
        end
      endcase
      if (!is_query) begin
        out_valid_nxt    = 1'b1;
        out_found_nxt    = 1'b0;
        out_length_nxt   = count_nxt;
        out_overflow_nxt = full && ((in_command == CMD_INS_HEAD) ||
                                    (in_command == CMD_INS_TAIL));
      end
    end else if (state_r == ST_RESOLVE) begin
      out_valid_nxt    = 1'b1;
      out_found_nxt    = hit;
      out_length_nxt   = count_r;
      out_overflow_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_found_r    <= out_found_nxt;
    out_length_r   <= out_length_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  // chain of cells, new pair enters at either end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [COORD_BITS-1:0] lx, ly, rx, ry;
    if (i == 0) begin : g_head
      assign lx = in_coord_x;
      assign ly = in_coord_y;
    end else begin : g_mid_l
      assign lx = x_w[i-1];
      assign ly = y_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rx = in_coord_x;
      assign ry = in_coord_y;
    end else begin : g_mid_r
      assign rx = x_w[i+1];
      assign ry = y_w[i+1];
    end
    cdss_cell #(
      .IDX        (i),
      .CNT_W      (CNT_W),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count_r),
      .count_m1 (count_m1),
      .new_x    (in_coord_x),
      .new_y    (in_coord_y),
      .left_x   (lx),
      .left_y   (ly),
      .right_x  (rx),
      .right_y  (ry),
      .x        (x_w[i]),
      .y        (y_w[i]),
      .match    (match_w[i])
    );
  end

  cdss_hit_tree #(
    .DEPTH (DEPTH)
  ) u_hit_tree (
    .clk   (clk),
    .match (match_w),
    .hit   (hit)
  );

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_length   = out_length_r;
  assign out_overflow = out_overflow_r;

endmodule
